@@ rtl/orbb_pkg.sv @@
// shared constants and types for the overwrite ring byte buffer
package orbb_pkg;

  localparam int DEPTH_DEFAULT     = 1024;
  localparam int MAX_BURST_DEFAULT = 64;

  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int OFF_W  = 10;
  localparam int CNT_W  = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BURST = 1'b1
  } state_t;

endpackage

@@ rtl/orbb_ram.sv @@
// generic single-write single-read ram with registered read data
module orbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/overwrite_ring_byte_buffer_core.sv @@
// top level of the overwrite ring byte buffer: control, pointers and byte ram
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | sink      | in_valid/in_ready   | kind write_byte request_length peek_offset
//   cfg     | sink      | cfg_valid/cfg_ready | cfg_data (capacity_in_use)
//   out     | source    | out_valid/out_ready | data_byte data_valid last overwrote
//           |           |                     | fill_count free_space is_empty is_full
//
// write, clear and empty read/peek requests stream at one per cycle while in_ready is high;
// their result is registered. a read or peek burst is accepted, then per byte the ram is
// read and the registered ram output is loaded into the result register before the next read.
// out_ready low holds the burst, and a waiting result blocks the next request.
// a capacity write waiting on cfg_valid goes ahead of a request in the same cycle.
// rst is synchronous; pointers and count go to zero, capacity to DEPTH; the ram is not cleared.
module overwrite_ring_byte_buffer_core #(
  parameter int DEPTH     = orbb_pkg::DEPTH_DEFAULT,
  parameter int MAX_BURST = orbb_pkg::MAX_BURST_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [orbb_pkg::KIND_W-1:0] kind,
  input  logic [orbb_pkg::BYTE_W-1:0] write_byte,
  input  logic [orbb_pkg::LEN_W-1:0]  request_length,
  input  logic [orbb_pkg::OFF_W-1:0]  peek_offset,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [orbb_pkg::CNT_W-1:0]  cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [orbb_pkg::BYTE_W-1:0] data_byte,
  output logic                       data_valid,
  output logic                       last,
  output logic                       overwrote,
  output logic [orbb_pkg::CNT_W-1:0]  fill_count,
  output logic [orbb_pkg::CNT_W-1:0]  free_space,
  output logic                       is_empty,
  output logic                       is_full
);

  import orbb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(MAX_BURST + 1);
  localparam int XW = ((CW > CNT_W) ? CW : CNT_W) + 1;

  state_t state, state_next;

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [AW-1:0] pos, pos_next;
  logic [CW-1:0] held, held_next;
  logic [CW-1:0] cap, cap_next;
  logic [RW-1:0] remaining, remaining_next;
  logic          burst_pop, burst_pop_next;
  logic          rd_pend;
  logic          rd_last, rd_last_next;

  logic          in_accept, cfg_accept, out_free, issue;
  logic          burst_start;

  logic [XW-1:0] len_sat, avail, n_bytes, held_x, off_x;
  logic [CW-1:0] cap_cfg;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic              out_load;
  logic [BYTE_W-1:0] o_byte;
  logic              o_valid, o_last, o_over;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                            input logic [AW-1:0] by,
                                            input logic [CW-1:0] c);
    logic [AW:0] s;
    s = {1'b0, idx} + {1'b0, by};
    if (s >= (AW + 1)'(c)) begin
      s = s - (AW + 1)'(c);
    end
    return s[AW-1:0];
  endfunction

  assign in_accept  = in_valid && in_ready;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign out_free   = !out_valid || out_ready;

  // burst sizing at accept time
  assign held_x  = XW'(held);
  assign off_x   = XW'(peek_offset);
  assign len_sat = (XW'(request_length) > XW'(MAX_BURST)) ? XW'(MAX_BURST)
                                                          : XW'(request_length);
  always_comb begin
    if (kind_t'(kind) == KIND_READ) begin
      avail = held_x;
    end else if (off_x < held_x) begin
      avail = held_x - off_x;
    end else begin
      avail = '0;
    end
  end
  assign n_bytes     = (len_sat < avail) ? len_sat : avail;
  assign burst_start = in_accept && (n_bytes != '0) &&
                       ((kind_t'(kind) == KIND_READ) || (kind_t'(kind) == KIND_PEEK));

  // out-of-range capacity is clamped into 1..DEPTH
  always_comb begin
    if (cfg_data == '0) begin
      cap_cfg = CW'(1);
    end else if (XW'(cfg_data) > XW'(DEPTH)) begin
      cap_cfg = CW'(DEPTH);
    end else begin
      cap_cfg = CW'(cfg_data);
    end
  end

  // fsm next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (burst_start) begin
          state_next = ST_BURST;
        end
      end
      ST_BURST: begin
        if (issue && (remaining == RW'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    issue     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = !rd_pend && out_free && !cfg_valid;
        cfg_ready = !rd_pend;
      end
      ST_BURST: begin
        issue = !rd_pend && out_free;
      end
      default: ;
    endcase
  end

  // pointer, count and result datapath
  always_comb begin
    head_next      = head;
    tail_next      = tail;
    pos_next       = pos;
    held_next      = held;
    cap_next       = cap;
    remaining_next = remaining;
    burst_pop_next = burst_pop;
    rd_last_next   = rd_last;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_re         = 1'b0;
    ram_raddr      = pos;
    out_load       = 1'b0;
    o_byte         = '0;
    o_valid        = 1'b0;
    o_last         = 1'b1;
    o_over         = 1'b0;

    if (cfg_accept) begin
      cap_next  = cap_cfg;
      head_next = '0;
      tail_next = '0;
      held_next = '0;
    end else if (in_accept) begin
      case (kind_t'(kind))
        KIND_WRITE: begin
          ram_we    = 1'b1;
          tail_next = advance(tail, AW'(1), cap);
          out_load  = 1'b1;
          if (held >= cap) begin
            // full: drop the oldest byte, count stays at capacity
            head_next = advance(head, AW'(1), cap);
            o_over    = 1'b1;
          end else begin
            held_next = held + CW'(1);
          end
        end
        KIND_CLEAR: begin
          head_next = '0;
          tail_next = '0;
          held_next = '0;
          out_load  = 1'b1;
        end
        KIND_READ, KIND_PEEK: begin
          if (n_bytes == '0) begin
            out_load = 1'b1;
          end else begin
            remaining_next = RW'(n_bytes);
            burst_pop_next = (kind_t'(kind) == KIND_READ);
            pos_next       = (kind_t'(kind) == KIND_READ) ? head
                                                         : advance(head, AW'(peek_offset), cap);
          end
        end
        default: ;
      endcase
    end

    if (issue) begin
      ram_re         = 1'b1;
      pos_next       = advance(pos, AW'(1), cap);
      remaining_next = remaining - RW'(1);
      rd_last_next   = (remaining == RW'(1));
      if (burst_pop) begin
        head_next = advance(head, AW'(1), cap);
        held_next = held - CW'(1);
      end
    end

    // ram data from the previous cycle's read lands in the result register
    if (rd_pend) begin
      out_load = 1'b1;
      o_byte   = ram_rdata;
      o_valid  = 1'b1;
      o_last   = rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      pos       <= '0;
      held      <= '0;
      cap       <= CW'(DEPTH);
      remaining <= '0;
      burst_pop <= 1'b0;
      rd_pend   <= 1'b0;
      rd_last   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      pos       <= pos_next;
      held      <= held_next;
      cap       <= cap_next;
      remaining <= remaining_next;
      burst_pop <= burst_pop_next;
      rd_pend   <= issue;
      rd_last   <= rd_last_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, status taken after this request's update
  always_ff @(posedge clk) begin
    if (out_load) begin
      data_byte  <= o_byte;
      data_valid <= o_valid;
      last       <= o_last;
      overwrote  <= o_over;
      fill_count <= CNT_W'(held_next);
      free_space <= CNT_W'(cap - held_next);
      is_empty   <= (held_next == '0);
      is_full    <= (held_next == cap);
    end
  end

  orbb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_byte_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (write_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ test/tb.sv @@
// self-checking testbench for the overwrite ring byte buffer core
module tb;
  import orbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  wbyte;
    logic [LEN_W-1:0]   len;
    logic [OFF_W-1:0]   off;
  } ring_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               data_valid;
    logic               last;
    logic               overwrote;
    logic [CNT_W-1:0]   fill_count;
    logic [CNT_W-1:0]   free_space;
    logic               is_empty;
    logic               is_full;
  } ring_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  kind = KIND_WRITE;
  logic [BYTE_W-1:0]  write_byte = '0;
  logic [LEN_W-1:0]   request_length = '0;
  logic [OFF_W-1:0]   peek_offset = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BYTE_W-1:0]  data_byte;
  logic               data_valid;
  logic               last;
  logic               overwrote;
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   free_space;
  logic               is_empty;
  logic               is_full;

  overwrite_ring_byte_buffer_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .write_byte     (write_byte),
    .request_length (request_length),
    .peek_offset    (peek_offset),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .data_valid     (data_valid),
    .last           (last),
    .overwrote      (overwrote),
    .fill_count     (fill_count),
    .free_space     (free_space),
    .is_empty       (is_empty),
    .is_full        (is_full)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ring shadow state
  logic [BYTE_W-1:0] ring_bytes [DEPTH_DEFAULT];
  int ring_head = 0;
  int ring_tail = 0;
  int ring_fill = 0;
  int ring_cap  = DEPTH_DEFAULT;

  ring_req_t    queued_requests[$];
  ring_result_t predicted_outputs[$];
  ring_req_t    cur_req;
  bit           request_live = 1'b0;
  int           send_gap = 0;
  int           recv_gap = 0;
  bit           send_idle_on = 1'b1;
  bit           recv_idle_on = 1'b1;
  bit           hold_arm = 1'b0;
  bit           hold_done = 1'b0;
  int           hold_left = 0;
  int           error_count = 0;
  int           quiet_cycles = 0;

  function automatic int wrap_add(int idx, int by);
    int s;
    s = idx + by;
    if (s >= ring_cap) s -= ring_cap;
    return s;
  endfunction

  function automatic void push_result(logic [BYTE_W-1:0] b, bit v, bit l, bit o);
    ring_result_t r;
    r.data_byte  = b;
    r.data_valid = v;
    r.last       = l;
    r.overwrote  = o;
    r.fill_count = CNT_W'(ring_fill);
    r.free_space = CNT_W'(ring_cap - ring_fill);
    r.is_empty   = (ring_fill == 0);
    r.is_full    = (ring_fill == ring_cap);
    predicted_outputs.push_back(r);
  endfunction

  function automatic void apply_to_ring(ring_req_t req);
    int want;
    int n;
    int pos;
    bit over;
    want = (req.len > MAX_BURST_DEFAULT) ? MAX_BURST_DEFAULT : int'(req.len);
    case (req.kind)
      KIND_WRITE: begin
        over = 1'b0;
        // full ring drops its oldest byte first
        if (ring_fill >= ring_cap) begin
          ring_head = wrap_add(ring_head, 1);
          ring_fill = ring_cap - 1;
          over = 1'b1;
        end
        ring_bytes[ring_tail] = req.wbyte;
        ring_tail = wrap_add(ring_tail, 1);
        ring_fill++;
        push_result('0, 1'b0, 1'b1, over);
      end
      KIND_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
        ring_fill = 0;
        push_result('0, 1'b0, 1'b1, 1'b0);
      end
      KIND_READ: begin
        if (ring_fill == 0 || want == 0) begin
          push_result('0, 1'b0, 1'b1, 1'b0);
        end else begin
          n = (want < ring_fill) ? want : ring_fill;
          for (int i = 0; i < n; i++) begin
            pos = ring_head;
            ring_head = wrap_add(ring_head, 1);
            ring_fill--;
            push_result(ring_bytes[pos], 1'b1, i + 1 == n, 1'b0);
          end
        end
      end
      default: begin
        if (want == 0 || int'(req.off) >= ring_fill) begin
          push_result('0, 1'b0, 1'b1, 1'b0);
        end else begin
          n = ring_fill - int'(req.off);
          if (want < n) n = want;
          pos = wrap_add(ring_head, int'(req.off));
          for (int i = 0; i < n; i++) begin
            push_result(ring_bytes[pos], 1'b1, i + 1 == n, 1'b0);
            pos = wrap_add(pos, 1);
          end
        end
      end
    endcase
  endfunction

  function automatic ring_req_t make_req(kind_t k, int b, int len, int off);
    ring_req_t req;
    req.kind  = k;
    req.wbyte = BYTE_W'(b);
    req.len   = LEN_W'(len);
    req.off   = OFF_W'(off);
    return req;
  endfunction

  function automatic ring_req_t random_request(int cap);
    ring_req_t req;
    int pick;
    int reach;
    reach = (cap > MAX_BURST_DEFAULT) ? MAX_BURST_DEFAULT : cap;
    pick = $urandom_range(0, 99);
    req.wbyte = BYTE_W'($urandom_range(0, 255));
    req.off = OFF_W'($urandom_range(0, (cap > 1023) ? 1023 : cap));
    if ($urandom_range(0, 7) == 0) req.off = OFF_W'($urandom_range(0, 1023));
    case ($urandom_range(0, 9))
      0: req.len = '0;
      1: req.len = LEN_W'($urandom_range(MAX_BURST_DEFAULT + 1, 127));
      default: req.len = LEN_W'($urandom_range(1, reach));
    endcase
    if (pick < 45) req.kind = KIND_WRITE;
    else if (pick < 70) req.kind = KIND_READ;
    else if (pick < 93) req.kind = KIND_PEEK;
    else req.kind = KIND_CLEAR;
    return req;
  endfunction

  function automatic string fmt_result(ring_result_t r);
    return $sformatf("byte %02h dv %0b last %0b ovr %0b fill %0d free %0d emp %0b full %0b",
                     r.data_byte, r.data_valid, r.last, r.overwrote, r.fill_count,
                     r.free_space, r.is_empty, r.is_full);
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
      request_live = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_to_ring(cur_req);
        request_live = 1'b0;
      end
      if (in_valid && !in_ready) begin
        // hold the request until it is taken
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (queued_requests.size() != 0) begin
        cur_req = queued_requests.pop_front();
        request_live = 1'b1;
        kind           <= cur_req.kind;
        write_byte     <= cur_req.wbyte;
        request_length <= cur_req.len;
        peek_offset    <= cur_req.off;
        in_valid       <= 1'b1;
        send_gap = send_idle_on ? $urandom_range(0, 12) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {data_byte, data_valid, last, overwrote, fill_count, free_space,
               is_empty, is_full};
        if (predicted_outputs.size() == 0) begin
          note_error($sformatf("unexpected result: %s", fmt_result(got)));
        end else begin
          want = predicted_outputs.pop_front();
          if (got !== want)
            note_error($sformatf("result mismatch\n  exp %s\n  got %s",
                                 fmt_result(want), fmt_result(got)));
        end
        recv_gap = recv_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        out_ready <= 1'b0;
        recv_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // long output stall, armed once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (queued_requests.size() != 0 || request_live || predicted_outputs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] value);
    int v;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    // zero acts as one, anything past the store depth as the depth
    v = int'(value);
    if (v < 1) v = 1;
    if (v > DEPTH_DEFAULT) v = DEPTH_DEFAULT;
    ring_cap  = v;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
  endtask

  task automatic run_phase(logic [CNT_W-1:0] cap_word, int count, bit send_idle,
                           bit recv_idle);
    wait_drained();
    send_idle_on = send_idle;
    recv_idle_on = recv_idle;
    write_capacity(cap_word);
    repeat (count) queued_requests.push_back(random_request(ring_cap));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests at the reset capacity
    queued_requests.push_back(make_req(KIND_READ,  0, 1, 0));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 1, 0));
    queued_requests.push_back(make_req(KIND_WRITE, 8'h00, 1, 0));
    queued_requests.push_back(make_req(KIND_WRITE, 8'hff, 127, 1023));
    queued_requests.push_back(make_req(KIND_WRITE, 8'ha5, 0, 0));
    queued_requests.push_back(make_req(KIND_WRITE, 8'h5a, 1, 0));
    queued_requests.push_back(make_req(KIND_READ,  0, 0, 0));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 0, 0));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 1, 0));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 64, 1));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 127, 3));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 1, 4));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 5, 1023));
    queued_requests.push_back(make_req(KIND_READ,  0, 2, 0));
    queued_requests.push_back(make_req(KIND_READ,  0, 127, 0));
    queued_requests.push_back(make_req(KIND_READ,  0, 1, 0));
    queued_requests.push_back(make_req(KIND_WRITE, 8'h3c, 1, 0));
    queued_requests.push_back(make_req(KIND_WRITE, 8'hc3, 1, 0));
    queued_requests.push_back(make_req(KIND_CLEAR, 0, 1, 0));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 1, 0));
    queued_requests.push_back(make_req(KIND_CLEAR, 0, 1, 0));
    queued_requests.push_back(make_req(KIND_WRITE, 8'h81, 1, 0));
    queued_requests.push_back(make_req(KIND_READ,  0, 64, 0));

    run_phase(11'd0, 8, 1'b1, 1'b1);
    run_phase(11'd1, 8, 1'b0, 1'b0);
    run_phase(11'd2, 10, 1'b1, 1'b1);
    run_phase(11'd5, 10, 1'b1, 1'b1);

    // output held off while requests keep coming, so the core backs up
    run_phase(11'd16, 0, 1'b0, 1'b1);
    hold_arm <= 1'b1;
    repeat (12) queued_requests.push_back(make_req(KIND_WRITE, $urandom_range(0, 255), 1, 0));
    repeat (8) queued_requests.push_back(random_request(ring_cap));

    run_phase(11'd37, 15, 1'b1, 1'b1);

    // oversized capacity word acts as the full store depth
    run_phase(11'h7ff, 0, 1'b1, 1'b1);
    repeat (5)
      queued_requests.push_back(make_req(KIND_WRITE, $urandom_range(0, 255), 1, 0));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 64, 1023));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 127, 0));
    queued_requests.push_back(make_req(KIND_READ,  0, 64, 0));
    queued_requests.push_back(make_req(KIND_PEEK,  0, 1, 0));
    queued_requests.push_back(make_req(KIND_WRITE, 8'h96, 1, 0));

    run_phase(11'd1024, 8, 1'b0, 1'b1);
    wait_drained();
    repeat (30) @(posedge clk);

    if (predicted_outputs.size() != 0)
      note_error($sformatf("%0d results never arrived", predicted_outputs.size()));
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
